// ===== sv/vcerf_pkg.sv =====
// Shared types, constants and helper functions of the CRTC and extension register front end.
package vcerf_pkg;

    localparam int EXT_REG_COUNT  = 128;
    localparam int EXT_IDX_W      = $clog2(EXT_REG_COUNT);
    localparam int CRTC_REG_COUNT = 25;
    localparam int CRTC_IDX_W     = 6;
    localparam int CRTC_ADDR_W    = $clog2(CRTC_REG_COUNT);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] PORT_SLEEP_ADDR     = 16'h0102;
    localparam logic [15:0] PORT_EXT_EN_ADDR    = 16'h0103;
    localparam logic [15:0] PORT_ID_ADDR        = 16'h0104;
    localparam logic [15:0] PORT_CRTC_IDX_ADDR  = 16'h03D4;
    localparam logic [15:0] PORT_CRTC_DATA_ADDR = 16'h03D5;
    localparam logic [15:0] PORT_EXT_IDX_ADDR   = 16'h03D6;
    localparam logic [15:0] PORT_EXT_DATA_ADDR  = 16'h03D7;
    localparam logic [15:0] PORT_SETUP_ADDR     = 16'h46E8;

    localparam logic [14:0] EXT_COLOUR_PAIR = 15'h01EB;  // 3D6/3D7
    localparam logic [14:0] EXT_MONO_PAIR   = 15'h01DB;  // 3B6/3B7
    localparam logic [11:0] COLOUR_BLOCK    = 12'h03D;
    localparam logic [11:0] MONO_BLOCK      = 12'h03B;
    localparam logic [7:0]  IO_3XX_PAGE     = 8'h03;
    localparam logic [15:0] REMAP_XOR       = 16'h0060;

    localparam logic [7:0] GLOBAL_ID     = 8'hA5;
    localparam logic [7:0] GATED_READ    = 8'hFF;
    localparam logic [7:0] CR07_WP_MASK  = 8'h10;

    localparam logic [CRTC_ADDR_W-1:0] CR_OVERFLOW    = CRTC_ADDR_W'(7);
    localparam logic [CRTC_ADDR_W-1:0] CR_VRETR_END   = CRTC_ADDR_W'(17);
    localparam logic [CRTC_IDX_W-1:0]  CR_CURSOR_LO   = CRTC_IDX_W'(14);
    localparam logic [CRTC_IDX_W-1:0]  CR_VRETR_START = CRTC_IDX_W'(16);
    localparam logic [EXT_IDX_W-1:0]   XR_PROTECT     = EXT_IDX_W'(21);

    typedef enum logic [3:0] {
        PK_SLEEP,
        PK_EXT_ENABLE,
        PK_GLOBAL_ID,
        PK_CRTC_INDEX,
        PK_CRTC_DATA,
        PK_EXT_INDEX,
        PK_EXT_DATA,
        PK_SETUP,
        PK_FORWARD,
        PK_GATED
    } port_kind_t;

    typedef struct packed {
        port_kind_t  kind;
        logic [15:0] addr;
    } decode_t;

    function automatic logic [7:0] ext_reset_value(input logic [EXT_IDX_W-1:0] idx);
        logic [7:0] v;
        unique case (idx)
            EXT_IDX_W'(0):  v = 8'h04;
            EXT_IDX_W'(1):  v = 8'h5A;
            EXT_IDX_W'(40): v = 8'h02;
            default:        v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/vga_crtc_extension_register_front_end_top.sv =====
// Top level of the CRTC and extension register front end.
//
// Usage:
//   Input channel s_*: one I/O request (s_command, s_port_address, s_write_data)
//   per valid/ready handshake. Result channel m_*: one result per request, in
//   order (m_read_data, m_forwarded, m_forward_address, m_timing_changed).
//   Configuration channel cfg_*: writes color_mode; cfg_ready is always high.
//   An accepted request enters the input register, then the result register.
//   Throughput: one request per cycle while m_ready is high; each request
//   is served in one pass of decode and register logic between the input
//   and result registers. Extension registers live in a 128-entry RAM with
//   registered read data read at the next extension index, and a bypass
//   for a write in the cycle before. Reset (aresetn low, synchronous) returns
//   all but the request, result data and bypass data registers to their
//   reset values at once; extension entries not yet written read their reset
//   value through per-entry valid bits, so no clearing pass is needed.
//   Receiver stall: the result is held while m_ready is low; one further
//   request is then taken into the input register and s_ready drops.
module vga_crtc_extension_register_front_end_top
    import vcerf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_port_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_forwarded,
    output logic [15:0] m_forward_address,
    output logic        m_timing_changed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_color_mode
);

    logic                   in_valid_reg;
    logic                   cmd_reg;
    logic [15:0]            addr_reg;
    logic [7:0]             wdata_reg;

    logic                   m_valid_reg;
    logic [7:0]             rd_reg, rd_next;
    logic                   fwd_reg, fwd_next;
    logic [15:0]            faddr_reg, faddr_next;
    logic                   timing_reg, timing_next;

    logic                   color_mode_reg;
    logic [7:0]             setup_reg, setup_next;
    logic [7:0]             sleep_reg, sleep_next;
    logic [7:0]             ext_en_reg, ext_en_next;
    logic [CRTC_IDX_W-1:0]  crtc_index_reg, crtc_index_next;
    logic [7:0]             crtc_regs_reg [CRTC_REG_COUNT];
    logic                   crtc_we;
    logic [7:0]             crtc_wdata;
    logic [EXT_IDX_W-1:0]   ext_index_reg, ext_index_next;
    logic [EXT_REG_COUNT-1:0] ext_valid_reg;
    logic                   xr_prot_reg, xr_prot_next;
    logic                   bypass_valid_reg;
    logic [7:0]             bypass_data_reg;

    logic                   ram_we;
    logic [7:0]             ram_rdata;
    logic [7:0]             ext_rd;

    logic                   advance;
    logic                   is_write;
    logic                   wp;
    logic [7:0]             crtc_old;
    logic [7:0]             rd;
    decode_t                dec;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign is_write  = (cmd_reg == CMD_WRITE);

    vcerf_decode u_decode (
        .port_address (addr_reg),
        .chip_enable  (setup_reg[3]),
        .ext_remap_en (ext_en_reg[6]),
        .color_mode   (color_mode_reg),
        .dec          (dec)
    );

    vcerf_ram #(
        .WIDTH (8),
        .DEPTH (EXT_REG_COUNT)
    ) u_ext_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ext_index_reg),
        .wdata (wdata_reg),
        .raddr (ext_index_next),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (bypass_valid_reg) begin
            ext_rd = bypass_data_reg;
        end else if (ext_valid_reg[ext_index_reg]) begin
            ext_rd = ram_rdata;
        end else begin
            ext_rd = ext_reset_value(ext_index_reg);
        end
    end

    assign wp       = crtc_regs_reg[CR_VRETR_END][7] || xr_prot_reg;
    assign crtc_old = crtc_regs_reg[crtc_index_reg[CRTC_ADDR_W-1:0]];

    always_comb begin
        rd              = GATED_READ;
        fwd_next        = 1'b0;
        faddr_next      = 16'h0000;
        timing_next     = 1'b0;
        setup_next      = setup_reg;
        sleep_next      = sleep_reg;
        ext_en_next     = ext_en_reg;
        crtc_index_next = crtc_index_reg;
        ext_index_next  = ext_index_reg;
        xr_prot_next    = xr_prot_reg;
        crtc_we         = 1'b0;
        crtc_wdata      = wdata_reg;
        ram_we          = 1'b0;
        if (advance) begin
            unique case (dec.kind)
                PK_SLEEP: begin
                    if (is_write) sleep_next = wdata_reg;
                    else rd = sleep_reg;
                end
                PK_EXT_ENABLE: begin
                    if (setup_reg[4]) begin
                        if (is_write) ext_en_next = wdata_reg;
                        else rd = ext_en_reg;
                    end
                end
                PK_GLOBAL_ID: begin
                    if (!is_write) rd = GLOBAL_ID;
                end
                PK_CRTC_INDEX: begin
                    if (is_write) crtc_index_next = wdata_reg[CRTC_IDX_W-1:0];
                    else rd = {2'b00, crtc_index_reg};
                end
                PK_CRTC_DATA: begin
                    if (crtc_index_reg < CRTC_IDX_W'(CRTC_REG_COUNT)) begin
                        if (!is_write) begin
                            rd = crtc_old;
                        end else if (!(wp && crtc_index_reg < CRTC_IDX_W'(CR_OVERFLOW))) begin
                            if (wp && crtc_index_reg[CRTC_ADDR_W-1:0] == CR_OVERFLOW) begin
                                crtc_wdata = (crtc_old & ~CR07_WP_MASK)
                                           | (wdata_reg & CR07_WP_MASK);
                            end
                            crtc_we = 1'b1;
                            timing_next = (crtc_old != crtc_wdata)
                                       && (crtc_index_reg < CR_CURSOR_LO
                                           || crtc_index_reg > CR_VRETR_START);
                        end
                    end
                end
                PK_EXT_INDEX: begin
                    if (ext_en_reg[7]) begin
                        if (is_write) ext_index_next = wdata_reg[EXT_IDX_W-1:0];
                        else rd = {1'b0, ext_index_reg};
                    end
                end
                PK_EXT_DATA: begin
                    if (ext_en_reg[7]) begin
                        if (is_write) begin
                            ram_we = 1'b1;
                            if (ext_index_reg == XR_PROTECT) xr_prot_next = wdata_reg[6];
                        end else begin
                            rd = ext_rd;
                        end
                    end
                end
                PK_SETUP: begin
                    if (is_write) setup_next = wdata_reg;
                end
                PK_FORWARD: begin
                    fwd_next   = 1'b1;
                    faddr_next = dec.addr;
                end
                PK_GATED: begin
                end
                default: begin
                end
            endcase
        end
        rd_next = is_write ? 8'h00 : rd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            color_mode_reg   <= 1'b0;
            setup_reg        <= 8'h00;
            sleep_reg        <= 8'h00;
            ext_en_reg       <= 8'h00;
            crtc_index_reg   <= '0;
            ext_index_reg    <= '0;
            ext_valid_reg    <= '0;
            xr_prot_reg      <= 1'b0;
            bypass_valid_reg <= 1'b0;
            for (int i = 0; i < CRTC_REG_COUNT; i++) begin
                crtc_regs_reg[i] <= 8'h00;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                color_mode_reg <= cfg_color_mode;
            end
            setup_reg        <= setup_next;
            sleep_reg        <= sleep_next;
            ext_en_reg       <= ext_en_next;
            crtc_index_reg   <= crtc_index_next;
            ext_index_reg    <= ext_index_next;
            xr_prot_reg      <= xr_prot_next;
            bypass_valid_reg <= ram_we;
            if (ram_we) begin
                ext_valid_reg[ext_index_reg] <= 1'b1;
            end
            if (crtc_we) begin
                crtc_regs_reg[crtc_index_reg[CRTC_ADDR_W-1:0]] <= crtc_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            addr_reg  <= s_port_address;
            wdata_reg <= s_write_data;
        end
        if (advance) begin
            rd_reg     <= rd_next;
            fwd_reg    <= fwd_next;
            faddr_reg  <= faddr_next;
            timing_reg <= timing_next;
        end
        if (ram_we) begin
            bypass_data_reg <= wdata_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = rd_reg;
    assign m_forwarded       = fwd_reg;
    assign m_forward_address = faddr_reg;
    assign m_timing_changed  = timing_reg;

    a_no_fwd_and_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_forwarded && m_timing_changed))
        else $error("forwarded request reports a timing change");

    a_fwd_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_forwarded |-> m_forward_address == 16'h0000)
        else $error("forward address set on a served request");

    a_timing_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timing_changed |-> m_read_data == 8'h00)
        else $error("timing change reported with read data");

    a_index_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(crtc_index_reg) && $stable(ext_index_reg))
        else $error("register index moved without a request");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with the result register empty");

endmodule

// ===== sv/vcerf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vcerf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vcerf_decode.sv =====
// Port gating, mono/colour and extension remapping, and served-port decode.
module vcerf_decode
    import vcerf_pkg::*;
(
    input  logic [15:0] port_address,
    input  logic        chip_enable,
    input  logic        ext_remap_en,
    input  logic        color_mode,
    output decode_t     dec
);

    logic [15:0] addr;

    always_comb begin
        addr = port_address;
        if (port_address[15:1] == EXT_COLOUR_PAIR || port_address[15:1] == EXT_MONO_PAIR) begin
            if (ext_remap_en) begin
                addr = port_address ^ REMAP_XOR;
            end
        end else if ((port_address[15:4] == COLOUR_BLOCK || port_address[15:4] == MONO_BLOCK)
                     && !color_mode) begin
            addr = port_address ^ REMAP_XOR;
        end
    end

    always_comb begin
        dec.addr = addr;
        if (!chip_enable && port_address[15:8] == IO_3XX_PAGE) begin
            dec.kind = PK_GATED;
        end else begin
            unique case (addr)
                PORT_SLEEP_ADDR:     dec.kind = PK_SLEEP;
                PORT_EXT_EN_ADDR:    dec.kind = PK_EXT_ENABLE;
                PORT_ID_ADDR:        dec.kind = PK_GLOBAL_ID;
                PORT_CRTC_IDX_ADDR:  dec.kind = PK_CRTC_INDEX;
                PORT_CRTC_DATA_ADDR: dec.kind = PK_CRTC_DATA;
                PORT_EXT_IDX_ADDR:   dec.kind = PK_EXT_INDEX;
                PORT_EXT_DATA_ADDR:  dec.kind = PK_EXT_DATA;
                PORT_SETUP_ADDR:     dec.kind = PK_SETUP;
                default:             dec.kind = PK_FORWARD;
            endcase
        end
    end

endmodule
